// ===== design/i2cee_pkg.sv =====
package i2cee_pkg;

  localparam int unsigned ADDR_W     = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WAIT_W     = 12;
  localparam int unsigned TIMEOUT_W  = 8;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic REG_ACK_TIMEOUT = 1'b0;
  localparam logic REG_WRITE_WAIT  = 1'b1;

  localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd255;
  localparam logic [WAIT_W-1:0]    WRITE_WAIT_RST  = 12'd1000;

  localparam logic [BYTE_W-1:0] DEV_BYTE_BASE = 8'hA0;

  // stage of the transfer: which byte the next ack closes
  localparam logic [1:0] STAGE_DEV  = 2'd0;
  localparam logic [1:0] STAGE_ADDR = 2'd1;
  localparam logic [1:0] STAGE_DATA = 2'd2;

  typedef enum logic [16:0] {
    PH_IDLE = 17'h00001,
    PH_ST0  = 17'h00002,
    PH_ST1  = 17'h00004,
    PH_ST2  = 17'h00008,
    PH_ST3  = 17'h00010,
    PH_TXL  = 17'h00020,
    PH_TXH  = 17'h00040,
    PH_AKL  = 17'h00080,
    PH_AKH  = 17'h00100,
    PH_RXL  = 17'h00200,
    PH_RXH  = 17'h00400,
    PH_NKL  = 17'h00800,
    PH_NKH  = 17'h01000,
    PH_SP0  = 17'h02000,
    PH_SP1  = 17'h04000,
    PH_SP2  = 17'h08000,
    PH_WAIT = 17'h10000
  } phase_t;

  // one classified tick
  typedef struct packed {
    logic              start_read;
    logic              start_write;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_data;
    logic              sda_in;
  } item_t;

endpackage

// ===== design/i2cee_front.sv =====
module i2cee_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i2cee_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                item_valid,
  output i2cee_pkg::item_t                    item,
  input  logic                                item_pop
);

  i2cee_pkg::item_t q_r [i2cee_pkg::QUEUE_DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push;
  logic             pop;
  i2cee_pkg::item_t in_item;

  // decode the command field once, on the way in
  always_comb begin
    in_item.start_read  = (in_tdata[1:0] == i2cee_pkg::CMD_READ);
    in_item.start_write = (in_tdata[1:0] == i2cee_pkg::CMD_WRITE);
    in_item.address     = in_tdata[12:2];
    in_item.write_data  = in_tdata[20:13];
    in_item.sda_in      = in_tdata[21];
  end

  assign in_tready  = (count_r != 2'(i2cee_pkg::QUEUE_DEPTH));
  assign push       = in_tvalid && in_tready;
  assign item_valid = (count_r != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(i2cee_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("push without pop did not grow the queue");

endmodule

// ===== design/i2cee_engine.sv =====
module i2cee_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [i2cee_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 item_valid,
  input  i2cee_pkg::item_t                     item,
  output logic                                 item_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [i2cee_pkg::OUT_DATA_W-1:0]     out_tdata
);

  i2cee_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]                       stage_r, stage_nxt;
  logic [3:0]                       bit_count_r, bit_count_nxt;
  logic [i2cee_pkg::BYTE_W-1:0]     shift_r, shift_nxt;
  logic [i2cee_pkg::WAIT_W-1:0]     wait_r, wait_nxt;
  logic [i2cee_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  logic [i2cee_pkg::BYTE_W-1:0]     data_r, data_nxt;
  logic                             is_read_r, is_read_nxt;
  logic [i2cee_pkg::BYTE_W-1:0]     last_read_r, last_read_nxt;
  logic [i2cee_pkg::TIMEOUT_W-1:0]  ack_timeout_r;
  logic [i2cee_pkg::WAIT_W-1:0]     write_wait_r;
  logic                             out_valid_r;
  logic [i2cee_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                             step;
  logic                             scl, sda, busy, done;
  logic [i2cee_pkg::BYTE_W-1:0]     dev_byte;

  assign step     = item_valid && (!out_valid_r || out_tready);
  assign item_pop = step;

  assign dev_byte = i2cee_pkg::DEV_BYTE_BASE
                  | {4'b0, addr_r[10:8], 1'b0}
                  | {7'b0, (stage_r == i2cee_pkg::STAGE_DATA)};

  always_comb begin
    phase_nxt     = phase_r;
    stage_nxt     = stage_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    wait_nxt      = wait_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    is_read_nxt   = is_read_r;
    last_read_nxt = last_read_r;
    scl  = 1'b1;
    sda  = 1'b1;
    busy = 1'b1;
    done = 1'b0;
    unique case (phase_r)
      i2cee_pkg::PH_ST0: begin
        scl = 1'b0;
        phase_nxt = i2cee_pkg::PH_ST1;
      end
      i2cee_pkg::PH_ST1: phase_nxt = i2cee_pkg::PH_ST2;
      i2cee_pkg::PH_ST2: begin
        sda = 1'b0;
        phase_nxt = i2cee_pkg::PH_ST3;
      end
      i2cee_pkg::PH_ST3: begin
        scl = 1'b0;
        sda = 1'b0;
        shift_nxt     = dev_byte;
        bit_count_nxt = 4'd0;
        phase_nxt     = i2cee_pkg::PH_TXL;
      end
      i2cee_pkg::PH_TXL: begin
        scl = 1'b0;
        sda = shift_r[7];
        phase_nxt = i2cee_pkg::PH_TXH;
      end
      i2cee_pkg::PH_TXH: begin
        sda = shift_r[7];
        shift_nxt     = {shift_r[6:0], 1'b0};
        bit_count_nxt = bit_count_r + 4'd1;
        phase_nxt     = (bit_count_nxt >= 4'd8) ? i2cee_pkg::PH_AKL : i2cee_pkg::PH_TXL;
      end
      i2cee_pkg::PH_AKL: begin
        scl = 1'b0;
        wait_nxt  = '0;
        phase_nxt = i2cee_pkg::PH_AKH;
      end
      i2cee_pkg::PH_AKH: begin
        if (!item.sda_in || (wait_r >= {4'b0, ack_timeout_r})) begin
          bit_count_nxt = 4'd0;
          if (stage_r == i2cee_pkg::STAGE_DEV) begin
            stage_nxt = i2cee_pkg::STAGE_ADDR;
            shift_nxt = addr_r[7:0];
            phase_nxt = i2cee_pkg::PH_TXL;
          end else if (stage_r == i2cee_pkg::STAGE_ADDR) begin
            stage_nxt = i2cee_pkg::STAGE_DATA;
            if (is_read_r) begin
              phase_nxt = i2cee_pkg::PH_ST0;   // repeated start
            end else begin
              shift_nxt = data_r;
              phase_nxt = i2cee_pkg::PH_TXL;
            end
          end else if (is_read_r) begin
            shift_nxt = '0;
            phase_nxt = i2cee_pkg::PH_RXL;
          end else begin
            phase_nxt = i2cee_pkg::PH_SP0;
          end
        end else begin
          wait_nxt = wait_r + 12'd1;
        end
      end
      i2cee_pkg::PH_RXL: begin
        scl = 1'b0;
        phase_nxt = i2cee_pkg::PH_RXH;
      end
      i2cee_pkg::PH_RXH: begin
        shift_nxt     = {shift_r[6:0], item.sda_in};
        bit_count_nxt = bit_count_r + 4'd1;
        phase_nxt     = (bit_count_nxt >= 4'd8) ? i2cee_pkg::PH_NKL : i2cee_pkg::PH_RXL;
      end
      i2cee_pkg::PH_NKL: begin
        scl = 1'b0;
        phase_nxt = i2cee_pkg::PH_NKH;
      end
      i2cee_pkg::PH_NKH: phase_nxt = i2cee_pkg::PH_SP0;
      i2cee_pkg::PH_SP0: begin
        scl = 1'b0;
        sda = 1'b0;
        phase_nxt = i2cee_pkg::PH_SP1;
      end
      i2cee_pkg::PH_SP1: begin
        sda = 1'b0;
        phase_nxt = i2cee_pkg::PH_SP2;
      end
      i2cee_pkg::PH_SP2: begin
        if (is_read_r) begin
          last_read_nxt = shift_r;
          done      = 1'b1;
          phase_nxt = i2cee_pkg::PH_IDLE;
        end else begin
          wait_nxt  = '0;
          phase_nxt = i2cee_pkg::PH_WAIT;
        end
      end
      i2cee_pkg::PH_WAIT: begin
        if (wait_r >= write_wait_r) begin
          done      = 1'b1;
          phase_nxt = i2cee_pkg::PH_IDLE;
        end else begin
          wait_nxt = wait_r + 12'd1;
        end
      end
      default: begin
        phase_nxt = i2cee_pkg::PH_IDLE;
        if (item.start_read || item.start_write) begin
          addr_nxt      = item.address;
          data_nxt      = item.write_data;
          is_read_nxt   = item.start_read;
          stage_nxt     = i2cee_pkg::STAGE_DEV;
          bit_count_nxt = 4'd0;
          wait_nxt      = '0;
          phase_nxt     = i2cee_pkg::PH_ST0;
        end else begin
          busy = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cee_pkg::PH_IDLE;
      stage_r     <= i2cee_pkg::STAGE_DEV;
      bit_count_r <= 4'd0;
      shift_r     <= '0;
      wait_r      <= '0;
      addr_r      <= '0;
      data_r      <= '0;
      is_read_r   <= 1'b0;
      last_read_r <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      stage_r     <= stage_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      wait_r      <= wait_nxt;
      addr_r      <= addr_nxt;
      data_r      <= data_nxt;
      is_read_r   <= is_read_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= i2cee_pkg::ACK_TIMEOUT_RST;
      write_wait_r  <= i2cee_pkg::WRITE_WAIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == i2cee_pkg::REG_ACK_TIMEOUT) begin
        ack_timeout_r <= cfg_data[7:0];
      end else begin
        write_wait_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {4'b0, last_read_nxt, done, busy, sda, scl};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[3]) |-> out_data_r[2])
    else $error("done result without busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    stage_r != 2'd3)
    else $error("illegal transfer stage");

  assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= 4'd8)
    else $error("bit count past one byte");

  assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == i2cee_pkg::PH_AKH && !item.sda_in) |=> (phase_r != i2cee_pkg::PH_AKH))
    else $error("ack low did not end the ack slot");

endmodule

// ===== design/i2c_eeprom_byte_access_master_core.sv =====
// Channel | Dir | Handshake            | Payload (low bit first)
// in      | in  | in_tvalid/in_tready  | cmd[1:0] address[12:2] write_data[20:13] sda_in[21]
// out     | out | out_tvalid/out_tready| scl[0] sda_out[1] busy_res[2] done_res[3] read_data[11:4]
// cfg     | in  | cfg_we               | cfg_index selects register, cfg_data value
//
// One item per clock while the output is not stalled; an item passes the queue, then its result is registered.
// A two-entry queue decouples the input side from the bus sequencer; the sequencer
// steps only when the result register is empty or being taken in the same cycle.
// A stalled output fills the queue, then drops in_tready.
// rst_n is synchronous; after reset the sequencer is idle with default timeouts.
module i2c_eeprom_byte_access_master_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // cmd, address, write_data, sda_in; bits 23:22 zero
  input  logic [i2cee_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // scl, sda_out, busy_res, done_res, read_data; bits 15:12 zero
  output logic [i2cee_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [i2cee_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic             item_valid;
  logic             item_pop;
  i2cee_pkg::item_t item;

  i2cee_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  i2cee_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
